// File: rtl/tuc_pkg.sv
// ----------------------------------------------------------------------------
// tuc_pkg
// Shared constants and beat types for the TCP/UDP over IPv4 checksum block.
// ----------------------------------------------------------------------------
package tuc_pkg;

   localparam int CountW           = 16;
   localparam int MaxPacketBytesDef = 65535;
   localparam int MidDepth         = 4;
   localparam int RspDepth         = 2;

   localparam int AddrFirst   = 12;
   localparam int AddrLast    = 19;
   localparam int MinIhl      = 5;
   localparam int TcpFixed    = 20;
   localparam int UdpFixed    = 8;
   localparam int TcpSkipWord = 8;
   localparam int UdpSkipWord = 3;
   localparam int ProtoTcp    = 6;
   localparam int ProtoUdp    = 17;

   typedef struct packed {
      logic              add;
      logic [15:0]       word;
      logic              last;
      logic              err;
      logic              tcp;
      logic [CountW-1:0] l4_len;
      logic [7:0]        pad_hi;
   } mid_entry_type;

   typedef struct packed {
      logic [15:0] checksum;
      logic        error;
   } rsp_entry_type;

endpackage

// File: rtl/tuc_fifo.sv
// ----------------------------------------------------------------------------
// tuc_fifo
// Small register queue with count based full and empty flags.
// ----------------------------------------------------------------------------
module tuc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             rd,
   output logic [WIDTH-1:0] rdata,
   output logic             full,
   output logic             empty
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic             do_wr, do_rd;

   assign full  = (cnt_ff == CntW'(DEPTH));
   assign empty = (cnt_ff == '0);
   assign do_wr = wr && !full;
   assign do_rd = rd && !empty;
   assign rdata = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// File: rtl/tuc_front.sv
// ----------------------------------------------------------------------------
// tuc_front
// Takes packet bytes, tracks the position in the packet, pairs bytes into
// words and marks which words enter the sum; works out the length and error
// of a packet on its last byte.
// ----------------------------------------------------------------------------
module tuc_front import tuc_pkg::*; #(
   parameter int MAX_PACKET_BYTES = MaxPacketBytesDef
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  logic [7:0]    req_data_byte,
   input  logic          req_op,
   input  logic          req_last,
   output mid_entry_type entry
);

   localparam logic [CountW-1:0] MaxPos = CountW'(MAX_PACKET_BYTES);

   logic [CountW-1:0] cnt_ff, cnt_in;
   logic [3:0]        ihl_ff, ihl_in;
   logic              tcp_ff, tcp_in;
   logic [7:0]        high_ff, high_in;

   logic [CountW-1:0] pos, total, off;
   logic [3:0]        ihl;
   logic [5:0]        hdr;
   logic              first, tcp, in_range, in_addr, hdr_ok, in_l4, take, odd;
   logic [CountW-2:0] skip;
   logic [CountW:0]   diff;
   logic [CountW-1:0] fixed;

   always_comb begin
      pos      = cnt_ff;
      first    = (pos == '0);
      ihl      = first ? req_data_byte[3:0] : ihl_ff;
      tcp      = first ? req_op : tcp_ff;
      hdr      = {ihl, 2'b00};
      in_range = (pos < MaxPos);
      in_addr  = (pos >= CountW'(AddrFirst)) && (pos <= CountW'(AddrLast));
      hdr_ok   = (ihl >= 4'(MinIhl));
      in_l4    = hdr_ok && (pos >= CountW'(hdr));
      off      = pos - CountW'(hdr);
      odd      = pos[0];
      skip     = tcp ? (CountW-1)'(TcpSkipWord) : (CountW-1)'(UdpSkipWord);
      take     = in_range && (in_addr || in_l4);
      high_in  = (take && !odd) ? req_data_byte : high_ff;
      total    = in_range ? pos + 1'b1 : pos;
      diff     = {1'b0, total} - (CountW+1)'(hdr);
      fixed    = tcp ? CountW'(TcpFixed) : CountW'(UdpFixed);

      entry.add    = take && odd && (in_addr || (off[CountW-1:1] != skip));
      entry.word   = {high_ff, req_data_byte};
      entry.last   = req_last;
      entry.err    = !hdr_ok || diff[CountW] || (diff[CountW-1:0] < fixed);
      entry.tcp    = tcp;
      entry.l4_len = diff[CountW-1:0];
      entry.pad_hi = diff[0] ? high_in : 8'h00;

      cnt_in = cnt_ff;
      ihl_in = ihl_ff;
      tcp_in = tcp_ff;
      if (accept) begin
         if (req_last) begin
            cnt_in = '0;
            ihl_in = '0;
            tcp_in = 1'b0;
         end else begin
            cnt_in = total;
            ihl_in = ihl;
            tcp_in = tcp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         ihl_ff <= '0;
         tcp_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         ihl_ff <= ihl_in;
         tcp_ff <= tcp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_ff <= '0;
      end else if (accept) begin
         high_ff <= high_in;
      end
   end

endmodule

// File: rtl/tuc_back.sv
// ----------------------------------------------------------------------------
// tuc_back
// Folds marked words into the running ones-complement sum and, on the last
// beat of a packet, adds the pseudo header trailer and forms the checksum.
// ----------------------------------------------------------------------------
module tuc_back import tuc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          mid_empty,
   input  mid_entry_type mid_entry,
   output logic          mid_pop,
   input  logic          rsp_full,
   output logic          rsp_wr,
   output rsp_entry_type rsp_entry
);

   typedef struct packed {
      logic [15:0]       sum;
      logic              err;
      logic              tcp;
      logic [CountW-1:0] l4_len;
      logic [7:0]        pad_hi;
   } fin_type;

   logic [15:0] running_ff, running_in;
   logic        fin_vld_ff, fin_vld_in;
   fin_type     fin_ff, fin_in;

   logic        fin_ready;
   logic [16:0] acc;
   logic [15:0] nsum;
   logic [17:0] total;
   logic [16:0] fold1;
   logic [15:0] fold2;

   always_comb begin
      rsp_wr    = fin_vld_ff && !rsp_full;
      fin_ready = !fin_vld_ff || !rsp_full;
      mid_pop   = !mid_empty && (!mid_entry.last || fin_ready);

      acc  = {1'b0, running_ff} + (mid_entry.add ? {1'b0, mid_entry.word} : 17'd0);
      nsum = acc[15:0] + 16'(acc[16]);

      running_in = running_ff;
      if (mid_pop) begin
         running_in = mid_entry.last ? 16'd0 : nsum;
      end

      fin_in.sum    = nsum;
      fin_in.err    = mid_entry.err;
      fin_in.tcp    = mid_entry.tcp;
      fin_in.l4_len = mid_entry.l4_len;
      fin_in.pad_hi = mid_entry.pad_hi;
      fin_vld_in    = (fin_vld_ff && !rsp_wr) || (mid_pop && mid_entry.last);

      total = 18'(fin_ff.sum) + 18'(fin_ff.l4_len) + 18'({fin_ff.pad_hi, 8'h00})
            + (fin_ff.tcp ? 18'(ProtoTcp) : 18'(ProtoUdp));
      fold1 = 17'(total[15:0]) + 17'(total[17:16]);
      fold2 = fold1[15:0] + 16'(fold1[16]);

      rsp_entry.checksum = fin_ff.err ? 16'd0 : ~fold2;
      rsp_entry.error    = fin_ff.err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= '0;
         fin_vld_ff <= 1'b0;
      end else begin
         running_ff <= running_in;
         fin_vld_ff <= fin_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mid_pop && mid_entry.last) begin
         fin_ff <= fin_in;
      end
   end

   a_sum_cleared: assert property (@(posedge clock) disable iff (reset)
      mid_pop && mid_entry.last |=> running_ff == 16'd0)
      else $error("running sum not cleared after the last beat of a packet");

   a_fin_holds: assert property (@(posedge clock) disable iff (reset)
      fin_vld_ff && !rsp_wr |=> fin_vld_ff && $stable(fin_ff))
      else $error("pending result lost while the result queue was full");

   a_word_no_wait: assert property (@(posedge clock) disable iff (reset)
      !mid_empty && !mid_entry.last |-> mid_pop)
      else $error("a word beat was held back in the accumulator");

endmodule

// File: rtl/tcp_udp_ipv4_checksum.sv
// ----------------------------------------------------------------------------
// tcp_udp_ipv4_checksum
// TCP or UDP checksum over an IPv4 packet streamed one byte per beat.
// ----------------------------------------------------------------------------
// The block takes one packet byte on every clock cycle while full is low,
// with no gap needed between bytes or packets, and gives one result per
// packet. The front part classifies each byte and queues it; the
// accumulator takes one queued beat per cycle, but holds a last beat back
// while an earlier result waits on a full result queue, and it adds a
// 16-bit word on every second byte that counts. The result of a packet
// is registered in the accumulator and waits there while the result queue
// is full; the input then stalls once the four-entry queue between the two
// parts has filled. The checksum is in network order with its first wire
// byte in bits 15:8, and it is zero whenever the error flag is set.
module tcp_udp_ipv4_checksum import tuc_pkg::*; #(
   parameter int MAX_PACKET_BYTES = MaxPacketBytesDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_op,
   input  logic        req_last,
   output logic        empty,
   input  logic        pop,
   output logic [15:0] rsp_checksum,
   output logic        rsp_error
);

   localparam int MidW = $bits(mid_entry_type);
   localparam int RspW = $bits(rsp_entry_type);

   logic          accept;
   mid_entry_type front_entry, mid_entry;
   logic [MidW-1:0] mid_rdata;
   logic          mid_empty, mid_pop;
   logic          rsp_full, rsp_wr;
   rsp_entry_type back_rsp, out_rsp;
   logic [RspW-1:0] rsp_rdata;

   assign accept       = push && !full;
   assign mid_entry    = mid_entry_type'(mid_rdata);
   assign out_rsp      = rsp_entry_type'(rsp_rdata);
   assign rsp_checksum = out_rsp.checksum;
   assign rsp_error    = out_rsp.error;

   tuc_front #(
      .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .req_data_byte (req_data_byte),
      .req_op        (req_op),
      .req_last      (req_last),
      .entry         (front_entry)
   );

   tuc_fifo #(
      .WIDTH (MidW),
      .DEPTH (MidDepth)
   ) u_mid_fifo (
      .clock (clock),
      .reset (reset),
      .wr    (accept),
      .wdata (front_entry),
      .rd    (mid_pop),
      .rdata (mid_rdata),
      .full  (full),
      .empty (mid_empty)
   );

   tuc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .mid_entry (mid_entry),
      .mid_pop   (mid_pop),
      .rsp_full  (rsp_full),
      .rsp_wr    (rsp_wr),
      .rsp_entry (back_rsp)
   );

   tuc_fifo #(
      .WIDTH (RspW),
      .DEPTH (RspDepth)
   ) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .wr    (rsp_wr),
      .wdata (back_rsp),
      .rd    (pop),
      .rdata (rsp_rdata),
      .full  (rsp_full),
      .empty (empty)
   );

endmodule
